// ===== hdl/jpsf_pkg.sv =====
// ----------------------------------------------------------------------------
// jpsf_pkg: shared types for the jump point successor finder
// Request and response item layouts, register indexes and request codes.
// ----------------------------------------------------------------------------
package jpsf_pkg;

  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_DEPTH     = 2048;
  localparam int MAP_AW        = 11;
  localparam int COORD_W       = 8;
  // Working coordinates carry two extra bits so that probes one or two
  // cells off the grid stay distinguishable.
  localparam int WCOORD_W      = COORD_W + 2;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_EXPAND = 1'b1;

  localparam logic [1:0] REG_GOAL_X     = 2'd0;
  localparam logic [1:0] REG_GOAL_Y     = 2'd1;
  localparam logic [1:0] REG_JUMP_LIMIT = 2'd2;

  typedef struct packed {
    logic                     req_type;
    logic [MAP_AW-1:0]        map_addr;
    logic [MAP_WORD_BITS-1:0] map_word;
    logic [COORD_W-1:0]       node_x;
    logic [COORD_W-1:0]       node_y;
    logic                     has_parent;
    logic [COORD_W-1:0]       parent_x;
    logic [COORD_W-1:0]       parent_y;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] succ_x;
    logic [COORD_W-1:0] succ_y;
    logic               last;
  } rsp_t;

endpackage

// ===== hdl/jump_point_successor_finder_core.sv =====
// ----------------------------------------------------------------------------
// jump_point_successor_finder_core
// Occupancy bitmap store and jump point scan sequencer for an octile grid.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  req     | in        | req_valid / req_ready   | req_t (map write or expand)
//  rsp     | out       | rsp_valid / rsp_ready   | rsp_t (one successor)
//  apb     | in/out    | psel, penable, pwrite   | goal_x, goal_y, jump_limit
//
// An expansion probes one cell at a time through the single registered map read
// port: a scan step makes five probes, or stops after the first when the next
// cell is blocked, and a diagonal step adds its two straight sub-scans. The length
// of an expansion follows the scanned distance.
// Reset clears control state and the registers; the map stays undefined.
// A full response register stalls the sequencer only when a new result is
// ready to be pushed; req_ready is high only while no expansion runs.
module jump_point_successor_finder_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  jpsf_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output jpsf_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import jpsf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_TSTART, S_TRING, S_TCOND, S_TBEGIN, S_TZERO,
    S_SSTEP, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_SQ4, S_SQ5,
    S_DSTEP, S_DQ0, S_DQ1, S_DQ2, S_DQ3, S_DQ4, S_DQ5,
    S_EMIT, S_FINISH
  } state_t;

  typedef logic signed [WCOORD_W-1:0] wc_t;
  typedef logic signed [2:0]          off_t;
  typedef logic signed [1:0]          dir_t;

  state_t      state;
  logic [7:0]  goal_x, goal_y;
  logic [15:0] jump_limit;

  logic [MAP_WORD_BITS-1:0] mem [MAP_DEPTH];
  logic [MAP_WORD_BITS-1:0] rd_word;
  logic [4:0]  rd_bit;
  logic        rd_off;
  logic        cell_open;

  wc_t   nx, ny;
  logic  ring_mode;
  dir_t  pdx, pdy;
  logic [3:0] k;

  wc_t   sx, sy, mx, my;
  dir_t  sdx, sdy, mdx, mdy;
  logic [15:0] scnt, mcnt;
  logic  caller_diag, sub_h;
  logic  v1;

  wc_t   res_x, res_y;
  logic  have_pend;
  logic [7:0] pend_x, pend_y;

  // Task list of the current expansion
  dir_t tdx, tdy;
  logic tcond, tcondx;
  logic [3:0] tcount;

  always_comb begin
    tdx = 2'sd0;
    tdy = 2'sd0;
    tcond = 1'b0;
    tcondx = 1'b0;
    tcount = 4'd3;
    if (ring_mode) begin
      tcount = 4'd8;
      case (k[2:0])
        3'd0: begin tdx = 2'sd0;  tdy = -2'sd1; end
        3'd1: begin tdx = 2'sd1;  tdy = -2'sd1; end
        3'd2: begin tdx = 2'sd1;  tdy = 2'sd0;  end
        3'd3: begin tdx = 2'sd1;  tdy = 2'sd1;  end
        3'd4: begin tdx = 2'sd0;  tdy = 2'sd1;  end
        3'd5: begin tdx = -2'sd1; tdy = 2'sd1;  end
        3'd6: begin tdx = -2'sd1; tdy = 2'sd0;  end
        default: begin tdx = -2'sd1; tdy = -2'sd1; end
      endcase
    end else if (pdx == 2'sd0) begin
      case (k[2:0])
        3'd0: begin tdx = 2'sd0; tdy = pdy; end
        3'd1: begin tdx = 2'sd1; tdy = pdy; tcond = 1'b1; tcondx = 1'b1; end
        default: begin tdx = -2'sd1; tdy = pdy; tcond = 1'b1; tcondx = 1'b1; end
      endcase
    end else if (pdy == 2'sd0) begin
      case (k[2:0])
        3'd0: begin tdx = pdx; tdy = 2'sd0; end
        3'd1: begin tdx = pdx; tdy = -2'sd1; tcond = 1'b1; end
        default: begin tdx = pdx; tdy = 2'sd1; tcond = 1'b1; end
      endcase
    end else begin
      tcount = 4'd5;
      case (k[2:0])
        3'd0: begin tdx = pdx; tdy = pdy; end
        3'd1: begin tdx = 2'sd0; tdy = pdy; end
        3'd2: begin tdx = pdx; tdy = 2'sd0; end
        3'd3: begin tdx = pdx; tdy = -pdy; tcond = 1'b1; end
        default: begin tdx = -pdx; tdy = pdy; tcond = 1'b1; tcondx = 1'b1; end
      endcase
    end
  end

  // Shared probe address unit: base cell plus a small offset
  wc_t  qbx, qby, qx, qy;
  off_t qox, qoy, sax, say, sdx3, sdy3, mdx3, mdy3, tdx3, tdy3;

  assign sdx3 = off_t'(sdx);
  assign sdy3 = off_t'(sdy);
  assign mdx3 = off_t'(mdx);
  assign mdy3 = off_t'(mdy);
  assign tdx3 = off_t'(tdx);
  assign tdy3 = off_t'(tdy);
  // Side offset of a straight scan: north for rows, west for columns.
  assign sax  = (sdy == 2'sd0) ? 3'sd0 : -3'sd1;
  assign say  = (sdy == 2'sd0) ? -3'sd1 : 3'sd0;

  always_comb begin
    qbx = nx;
    qby = ny;
    qox = 3'sd0;
    qoy = 3'sd0;
    case (state)
      S_TSTART: begin
        if (ring_mode) begin
          qox = tdx3;
          qoy = tdy3;
        end else if (tcondx) begin
          qox = tdx3;
        end else begin
          qoy = tdy3;
        end
      end
      S_SQ0: begin qbx = sx; qby = sy; end
      S_SQ1: begin qbx = sx; qby = sy; qox = sax; qoy = say; end
      S_SQ2: begin qbx = sx; qby = sy; qox = sax + sdx3; qoy = say + sdy3; end
      S_SQ3: begin qbx = sx; qby = sy; qox = -sax; qoy = -say; end
      S_SQ4: begin qbx = sx; qby = sy; qox = sdx3 - sax; qoy = sdy3 - say; end
      S_DQ0: begin qbx = mx; qby = my; end
      S_DQ1: begin qbx = mx; qby = my; qox = -mdx3; end
      S_DQ2: begin qbx = mx; qby = my; qox = -mdx3; qoy = mdy3; end
      S_DQ3: begin qbx = mx; qby = my; qoy = -mdy3; end
      S_DQ4: begin qbx = mx; qby = my; qox = mdx3; qoy = -mdy3; end
      default: begin qbx = nx; qby = ny; end
    endcase
  end

  assign qx = qbx + wc_t'(qox);
  assign qy = qby + wc_t'(qoy);

  logic [MAP_AW-1:0] rd_addr;
  assign rd_addr = {qy[7:0], qx[7:5]};

  always_ff @(posedge clk) begin
    if (req_valid && req_ready && req.req_type == REQ_WRITE) begin
      mem[req.map_addr] <= req.map_word;
    end
    rd_word <= mem[rd_addr];
    rd_bit  <= qx[4:0];
    rd_off  <= (qx[WCOORD_W-1:COORD_W] != 2'b00) || (qy[WCOORD_W-1:COORD_W] != 2'b00);
  end

  assign cell_open = !rd_off && rd_word[rd_bit];

  logic s_goal, m_goal;
  assign s_goal = (sx == wc_t'({2'b00, goal_x})) && (sy == wc_t'({2'b00, goal_y}));
  assign m_goal = (mx == wc_t'({2'b00, goal_x})) && (my == wc_t'({2'b00, goal_y}));

  logic slot_free;
  logic rsp_load;
  assign slot_free = !rsp_valid || rsp_ready;
  assign rsp_load  = slot_free && ((state == S_EMIT && have_pend) || state == S_FINISH);
  assign req_ready = (state == S_IDLE);

  // APB registers
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_GOAL_X:     prdata = {24'd0, goal_x};
      REG_GOAL_Y:     prdata = {24'd0, goal_y};
      REG_JUMP_LIMIT: prdata = {16'd0, jump_limit};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x <= 8'd0;
      goal_y <= 8'd0;
      jump_limit <= 16'hFFFF;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_GOAL_X:     goal_x <= pwdata[7:0];
        REG_GOAL_Y:     goal_y <= pwdata[7:0];
        REG_JUMP_LIMIT: jump_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      have_pend <= 1'b0;
      k         <= 4'd0;
    end else begin
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid && req.req_type == REQ_EXPAND) begin
            nx <= wc_t'({2'b00, req.node_x});
            ny <= wc_t'({2'b00, req.node_y});
            ring_mode <= !req.has_parent;
            if (req.parent_y == req.node_y) begin
              pdx <= (req.parent_x > req.node_x) ? -2'sd1 : 2'sd1;
              pdy <= 2'sd0;
            end else begin
              pdy <= (req.parent_y < req.node_y) ? 2'sd1 : -2'sd1;
              pdx <= (req.parent_x < req.node_x) ? 2'sd1 :
                     ((req.parent_x > req.node_x) ? -2'sd1 : 2'sd0);
            end
            k <= 4'd0;
            state <= S_TSTART;
          end
        end
        S_TSTART: begin
          if (k == tcount) state <= S_FINISH;
          else if (ring_mode) state <= S_TRING;
          else if (tcond) state <= S_TCOND;
          else state <= S_TBEGIN;
        end
        S_TRING: begin
          if (cell_open) begin
            res_x <= nx + wc_t'(tdx);
            res_y <= ny + wc_t'(tdy);
            state <= S_EMIT;
          end else begin
            k <= k + 4'd1;
            state <= S_TSTART;
          end
        end
        S_TCOND: begin
          if (cell_open) begin
            k <= k + 4'd1;
            state <= S_TSTART;
          end else begin
            state <= S_TBEGIN;
          end
        end
        S_TBEGIN: begin
          if (jump_limit == 16'd0) begin
            state <= S_TZERO;
          end else if (tdx != 2'sd0 && tdy != 2'sd0) begin
            mx <= nx; my <= ny; mdx <= tdx; mdy <= tdy;
            mcnt <= 16'd0;
            state <= S_DSTEP;
          end else begin
            sx <= nx; sy <= ny; sdx <= tdx; sdy <= tdy;
            scnt <= 16'd0;
            caller_diag <= 1'b0;
            state <= S_SSTEP;
          end
        end
        S_TZERO: begin
          if (cell_open) begin
            res_x <= nx;
            res_y <= ny;
            state <= S_EMIT;
          end else begin
            k <= k + 4'd1;
            state <= S_TSTART;
          end
        end
        S_SSTEP: begin
          if (scnt == jump_limit) begin
            res_x <= caller_diag ? mx : sx;
            res_y <= caller_diag ? my : sy;
            state <= S_EMIT;
          end else begin
            sx <= sx + wc_t'(sdx);
            sy <= sy + wc_t'(sdy);
            scnt <= scnt + 16'd1;
            state <= S_SQ0;
          end
        end
        S_SQ0: state <= S_SQ1;
        S_SQ1, S_SQ3, S_SQ5: begin
          if ((state == S_SQ1 && cell_open && s_goal) ||
              (state != S_SQ1 && !v1 && cell_open)) begin
            res_x <= caller_diag ? mx : sx;
            res_y <= caller_diag ? my : sy;
            state <= S_EMIT;
          end else if (state == S_SQ1 && !cell_open) begin
            // Blocked or off the grid: the straight scan yields nothing.
            if (!caller_diag) begin
              k <= k + 4'd1;
              state <= S_TSTART;
            end else if (!sub_h) begin
              sub_h <= 1'b1;
              sx <= mx; sy <= my; sdx <= mdx; sdy <= 2'sd0;
              scnt <= 16'd0;
              state <= S_SSTEP;
            end else begin
              state <= S_DSTEP;
            end
          end else if (state == S_SQ1) begin
            state <= S_SQ2;
          end else if (state == S_SQ3) begin
            state <= S_SQ4;
          end else begin
            state <= S_SSTEP;
          end
        end
        S_SQ2, S_SQ4: begin
          v1 <= cell_open;
          state <= (state == S_SQ2) ? S_SQ3 : S_SQ5;
        end
        S_DSTEP: begin
          if (mcnt == jump_limit) begin
            res_x <= mx;
            res_y <= my;
            state <= S_EMIT;
          end else begin
            mx <= mx + wc_t'(mdx);
            my <= my + wc_t'(mdy);
            mcnt <= mcnt + 16'd1;
            state <= S_DQ0;
          end
        end
        S_DQ0: state <= S_DQ1;
        S_DQ1, S_DQ3, S_DQ5: begin
          if ((state == S_DQ1 && cell_open && m_goal) ||
              (state != S_DQ1 && !v1 && cell_open)) begin
            res_x <= mx;
            res_y <= my;
            state <= S_EMIT;
          end else if (state == S_DQ1 && !cell_open) begin
            k <= k + 4'd1;
            state <= S_TSTART;
          end else if (state == S_DQ1) begin
            state <= S_DQ2;
          end else if (state == S_DQ3) begin
            state <= S_DQ4;
          end else begin
            // Vertical sub-scan first, then the horizontal one.
            sx <= mx; sy <= my; sdx <= 2'sd0; sdy <= mdy;
            scnt <= 16'd0;
            caller_diag <= 1'b1;
            sub_h <= 1'b0;
            state <= S_SSTEP;
          end
        end
        S_DQ2, S_DQ4: begin
          v1 <= cell_open;
          state <= (state == S_DQ2) ? S_DQ3 : S_DQ5;
        end
        S_EMIT: begin
          // The newest result is held back until it is known whether it is last.
          if (!have_pend || slot_free) begin
            if (have_pend) begin
              rsp <= '{found: 1'b1, succ_x: pend_x, succ_y: pend_y, last: 1'b0};
            end
            pend_x <= res_x[7:0];
            pend_y <= res_y[7:0];
            have_pend <= 1'b1;
            k <= k + 4'd1;
            state <= S_TSTART;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            if (have_pend) begin
              rsp <= '{found: 1'b1, succ_x: pend_x, succ_y: pend_y, last: 1'b1};
            end else begin
              rsp <= '{found: 1'b0, succ_x: 8'd0, succ_y: 8'd0, last: 1'b1};
            end
            have_pend <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.last)
    else $error("empty marker without last");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> (rsp.succ_x == 8'd0 && rsp.succ_y == 8'd0))
    else $error("empty marker with coordinates");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !have_pend)
    else $error("held result left behind");
  a_straight_dir: assert property (@(posedge clk) disable iff (rst)
    state == S_SQ0 |-> ((sdx == 2'sd0) != (sdy == 2'sd0)))
    else $error("straight scan with bad direction");
`endif

endmodule

// ===== bench/jpsf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpsf_checker: successor prediction and response comparison
// Watches the request, response and register ports of the jump point
// successor finder, keeps its own copy of the bitmap and registers, works out
// the successors of every accepted expansion and compares each response item.
// ----------------------------------------------------------------------------
module jpsf_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  jpsf_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  jpsf_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic           pready,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output int             errors,
  output int             pending,
  output int             results,
  output int             empty_sets
);
  import jpsf_pkg::*;

  localparam int GRID = 256;

  logic [MAP_WORD_BITS-1:0] occ [MAP_DEPTH];
  int unsigned goal_col;
  int unsigned goal_row;
  int unsigned step_limit;
  rsp_t succ_q[$];

  function automatic bit cell_free(int x, int y);
    int idx;
    if (x < 0 || y < 0 || x >= GRID || y >= GRID) return 1'b0;
    idx = y * GRID + x;
    return occ[idx / MAP_WORD_BITS][idx % MAP_WORD_BITS];
  endfunction

  function automatic bit is_goal(int x, int y);
    return x == int'(goal_col) && y == int'(goal_row);
  endfunction

  function automatic bit walk_line(int dx, int dy, int x, int y,
                                   output int rx, output int ry);
    int cx;
    int cy;
    cx = x;
    cy = y;
    rx = 0;
    ry = 0;
    if (!cell_free(cx, cy) && step_limit == 0) return 1'b0;
    for (int s = 1; s <= int'(step_limit); s++) begin
      cx += dx;
      cy += dy;
      if (!cell_free(cx, cy)) return 1'b0;
      if (is_goal(cx, cy)) break;
      if (dy == 0) begin
        if (!cell_free(cx, cy - 1) && cell_free(cx + dx, cy - 1)) break;
        if (!cell_free(cx, cy + 1) && cell_free(cx + dx, cy + 1)) break;
      end else begin
        if (!cell_free(cx - 1, cy) && cell_free(cx - 1, cy + dy)) break;
        if (!cell_free(cx + 1, cy) && cell_free(cx + 1, cy + dy)) break;
      end
    end
    rx = cx;
    ry = cy;
    return 1'b1;
  endfunction

  function automatic bit walk_dir(int dx, int dy, int x, int y,
                                  output int rx, output int ry);
    int cx;
    int cy;
    int tx;
    int ty;
    cx = x;
    cy = y;
    rx = 0;
    ry = 0;
    if (dx == 0 || dy == 0) return walk_line(dx, dy, x, y, rx, ry);
    if (!cell_free(cx, cy) && step_limit == 0) return 1'b0;
    for (int s = 1; s <= int'(step_limit); s++) begin
      cx += dx;
      cy += dy;
      if (!cell_free(cx, cy)) return 1'b0;
      if (is_goal(cx, cy)) break;
      if (!cell_free(cx - dx, cy) && cell_free(cx - dx, cy + dy)) break;
      if (!cell_free(cx, cy - dy) && cell_free(cx + dx, cy - dy)) break;
      if (walk_line(0, dy, cx, cy, tx, ty) || walk_line(dx, 0, cx, cy, tx, ty)) break;
    end
    rx = cx;
    ry = cy;
    return 1'b1;
  endfunction

  function automatic rsp_t succ_item(int x, int y);
    rsp_t r;
    r.found = 1'b1;
    r.succ_x = x[7:0];
    r.succ_y = y[7:0];
    r.last = 1'b0;
    return r;
  endfunction

  // Scans one direction and appends its jump point, if any.
  task automatic try_heading(ref rsp_t found_q[$], input int dx, input int dy,
                             input int x, input int y);
    int rx;
    int ry;
    if (walk_dir(dx, dy, x, y, rx, ry) && found_q.size() < 8)
      found_q.insert(found_q.size(), succ_item(rx, ry));
  endtask

  task automatic predict_expansion(input req_t r);
    int ring_x[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
    int ring_y[8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
    rsp_t found_q[$];
    rsp_t none;
    int x;
    int y;
    int px;
    int py;
    int dx;
    int dy;
    x = int'(r.node_x);
    y = int'(r.node_y);
    if (!r.has_parent) begin
      for (int i = 0; i < 8; i++)
        if (cell_free(x + ring_x[i], y + ring_y[i]))
          found_q.insert(found_q.size(), succ_item(x + ring_x[i], y + ring_y[i]));
    end else begin
      px = int'(r.parent_x);
      py = int'(r.parent_y);
      // A parent in the same row, including one on the node, sends travel east
      // unless it lies to the east.
      if (py == y) begin
        dx = (px > x) ? -1 : 1;
        dy = 0;
      end else begin
        dy = (py < y) ? 1 : -1;
        dx = (px < x) ? 1 : ((px > x) ? -1 : 0);
      end
      if (dx == 0) begin
        try_heading(found_q, 0, dy, x, y);
        if (!cell_free(x + 1, y)) try_heading(found_q, 1, dy, x, y);
        if (!cell_free(x - 1, y)) try_heading(found_q, -1, dy, x, y);
      end else if (dy == 0) begin
        try_heading(found_q, dx, 0, x, y);
        if (!cell_free(x, y - 1)) try_heading(found_q, dx, -1, x, y);
        if (!cell_free(x, y + 1)) try_heading(found_q, dx, 1, x, y);
      end else begin
        try_heading(found_q, dx, dy, x, y);
        try_heading(found_q, 0, dy, x, y);
        try_heading(found_q, dx, 0, x, y);
        if (!cell_free(x, y - dy)) try_heading(found_q, dx, -dy, x, y);
        if (!cell_free(x - dx, y)) try_heading(found_q, -dx, dy, x, y);
      end
    end
    if (found_q.size() == 0) begin
      none = '0;
      none.last = 1'b1;
      succ_q.insert(succ_q.size(), none);
      empty_sets++;
    end else begin
      found_q[found_q.size() - 1].last = 1'b1;
      foreach (found_q[i]) succ_q.insert(succ_q.size(), found_q[i]);
    end
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    errors++;
  endtask

  initial begin
    errors = 0;
    results = 0;
    empty_sets = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      goal_col = 0;
      goal_row = 0;
      step_limit = 65535;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_GOAL_X:     goal_col = 32'(pwdata[7:0]);
          REG_GOAL_Y:     goal_row = 32'(pwdata[7:0]);
          REG_JUMP_LIMIT: step_limit = 32'(pwdata[15:0]);
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        results++;
        if (succ_q.size() == 0) begin
          $display("%0t: response item with no successor expected", $realtime);
          errors++;
        end else begin
          want = succ_q.pop_front();
          if (rsp.found !== want.found) report_mismatch("found", want.found, rsp.found);
          if (rsp.succ_x !== want.succ_x) report_mismatch("succ_x", want.succ_x, rsp.succ_x);
          if (rsp.succ_y !== want.succ_y) report_mismatch("succ_y", want.succ_y, rsp.succ_y);
          if (rsp.last !== want.last) report_mismatch("last", want.last, rsp.last);
        end
      end
      if (req_valid && req_ready) begin
        if (req.req_type == REQ_WRITE) occ[req.map_addr] = req.map_word;
        else predict_expansion(req);
      end
    end
    pending <= succ_q.size();
  end

endmodule

// ===== bench/tb_jump_point_successor_finder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jump_point_successor_finder_core: stimulus and verdict
// Writes the bitmap around two small open regions at opposite corners and a
// blocked patch in the middle, then runs directed and random expansions and
// map rewrites under several goal and jump limit settings, with random gaps
// on both channels.
// ----------------------------------------------------------------------------
module tb_jump_point_successor_finder_core;
  import jpsf_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int results;
  int empty_sets;
  int items_sent;
  int expansions;
  int idle_cycles;
  bit gaps_on;
  bit stalls_on;
  int stall_left;

  jump_point_successor_finder_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  jpsf_checker chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending), .results(results), .empty_sets(empty_sets)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(input req_t r);
    int g;
    g = gaps_on ? gap_len() : 0;
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(negedge clk); while (!req_ready);
    @(posedge clk);
    items_sent++;
    if (r.req_type == REQ_EXPAND) expansions++;
  endtask

  task automatic write_map(input int addr, input logic [31:0] word);
    logic [95:0] raw;
    req_t r;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    r.req_type = REQ_WRITE;
    r.map_addr = addr[MAP_AW-1:0];
    r.map_word = word;
    send_item(r);
  endtask

  task automatic expand(input int x, input int y, input bit hp, input int px, input int py);
    logic [95:0] raw;
    req_t r;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    r.req_type = REQ_EXPAND;
    r.node_x = x[7:0];
    r.node_y = y[7:0];
    r.has_parent = hp;
    r.parent_x = px[7:0];
    r.parent_y = py[7:0];
    send_item(r);
  endtask

  // Holds the request channel until the block has delivered every result.
  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] region_word();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return $urandom & $urandom;
      default: return $urandom | $urandom;
    endcase
  endfunction

  // Open cells lie in word column 0 of rows 0..15 and word column 7 of rows
  // 240..255; a blocked border of written words lines each region's inner sides.
  task automatic rewrite_region();
    int y;
    if ($urandom_range(0, 1)) begin
      y = $urandom_range(0, 15);
      write_map(y * 8, region_word());
    end else begin
      y = $urandom_range(240, 255);
      write_map(y * 8 + 7, region_word());
    end
  endtask

  task automatic random_expand();
    int x;
    int y;
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      x = $urandom_range(0, 32);
      y = $urandom_range(0, 16);
    end else if (r < 8) begin
      x = $urandom_range(223, 255);
      y = $urandom_range(239, 255);
    end else begin
      x = $urandom_range(97, 126);
      y = $urandom_range(99, 101);
    end
    r = $urandom_range(0, 19);
    if (r < 3) expand(x, y, 1'b0, $urandom_range(0, 255), $urandom_range(0, 255));
    else if (r < 5) expand(x, y, 1'b1, $urandom_range(0, 255), $urandom_range(0, 255));
    else if (r < 6) expand(x, y, 1'b1, x, y);
    else expand(x, y, 1'b1, x + $urandom_range(0, 6) - 3, y + $urandom_range(0, 6) - 3);
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) rewrite_region();
      else random_expand();
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    items_sent = 0;
    expansions = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int y = 0; y < 18; y++) begin
      write_map(y * 8, (y < 16) ? region_word() : 32'h0);
      write_map(y * 8 + 1, 32'h0);
    end
    for (int y = 238; y < 256; y++) begin
      write_map(y * 8 + 6, 32'h0);
      write_map(y * 8 + 7, (y >= 240) ? region_word() : 32'h0);
    end
    for (int y = 98; y < 103; y++) write_map(y * 8 + 3, 32'h0);
    write_map(0, 32'hFFFF_FFFF);
    write_map(255 * 8 + 7, 32'hFFFF_FFFF);
    drain();
    reg_write(REG_GOAL_X, 32'd20);
    reg_write(REG_GOAL_Y, 32'd6);
    reg_write(REG_JUMP_LIMIT, 32'd65535);

    // Directed: corners, all eight parent directions, degenerate parents.
    gaps_on = 1'b1;
    expand(0, 0, 1'b0, 0, 0);
    expand(255, 255, 1'b0, 0, 0);
    expand(5, 5, 1'b0, 0, 0);
    for (int dy = -1; dy <= 1; dy++)
      for (int dx = -1; dx <= 1; dx++)
        if (dx != 0 || dy != 0) expand(10, 8, 1'b1, 10 + dx, 8 + dy);
    expand(10, 8, 1'b1, 10, 8);
    expand(10, 8, 1'b1, 200, 8);
    expand(100, 100, 1'b1, 99, 99);
    expand(100, 100, 1'b0, 0, 0);
    expand(0, 0, 1'b1, 255, 255);
    expand(255, 255, 1'b1, 0, 0);
    expand(20, 6, 1'b1, 19, 6);
    drain();

    reg_write(REG_JUMP_LIMIT, 32'd0);
    expand(0, 0, 1'b1, 0, 1);
    expand(100, 100, 1'b1, 99, 100);
    expand(3, 3, 1'b1, 2, 2);
    drain();

    stalls_on = 1'b1;
    reg_write(REG_GOAL_X, 32'd255);
    reg_write(REG_GOAL_Y, 32'd255);
    reg_write(REG_JUMP_LIMIT, 32'd1);
    random_phase(12);
    drain();

    reg_write(REG_GOAL_X, 32'd0);
    reg_write(REG_GOAL_Y, 32'd0);
    reg_write(REG_JUMP_LIMIT, $urandom_range(2, 20));
    gaps_on = 1'b0;
    random_phase(12);
    drain();

    gaps_on = 1'b1;
    reg_write(REG_GOAL_X, $urandom_range(0, 31));
    reg_write(REG_GOAL_Y, $urandom_range(0, 15));
    reg_write(REG_JUMP_LIMIT, 32'd65535);
    random_phase(12);
    drain();

    stalls_on = 1'b0;
    reg_write(REG_GOAL_X, $urandom_range(224, 255));
    reg_write(REG_GOAL_Y, $urandom_range(240, 255));
    random_phase(12);
    drain();

    stalls_on = 1'b1;
    reg_write(REG_JUMP_LIMIT, $urandom_range(1, 65535));
    random_phase(12);
    drain();
    repeat (100) @(posedge clk);

    $display("Sent %0d items, %0d of them expansions, under seven register settings.",
             items_sent, expansions);
    $display("Checked %0d response items, %0d of them empty sets.", results, empty_sets);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
